/* design/script_token_scanner_core_assert.svh */
// Assertion macros for the script token scanner core.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef SCRIPT_TOKEN_SCANNER_CORE_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while in reset.
`define STST_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner assertion failed");
// Next-cycle implication, sampled on clk, off while in reset.
`define STST_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner assertion failed");
`else
`define STST_ASSERT_IMP(label, ante, cons)
`define STST_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* design/stst_pkg.sv */
// Shared types, token kind codes, character constants and classifier functions
// for the script token scanner. No dependencies.
package stst_pkg;

	localparam int KW_CHARS = 8;
	localparam int KW_COUNT = 16;

	localparam logic [5:0] KIND_EOF      = 6'd0;
	localparam logic [5:0] KIND_NEWLINE  = 6'd1;
	localparam logic [5:0] KIND_KEYWORD  = 6'd2;
	localparam logic [5:0] KIND_IDENT    = 6'd3;
	localparam logic [5:0] KIND_INT      = 6'd4;
	localparam logic [5:0] KIND_FLOAT    = 6'd5;
	localparam logic [5:0] KIND_STRING   = 6'd6;
	localparam logic [5:0] KIND_ERROR    = 6'd7;
	localparam logic [5:0] KIND_PLUS     = 6'd8;
	localparam logic [5:0] KIND_MINUS    = 6'd9;
	localparam logic [5:0] KIND_STAR     = 6'd10;
	localparam logic [5:0] KIND_SLASH    = 6'd11;
	localparam logic [5:0] KIND_ASSIGN   = 6'd12;
	localparam logic [5:0] KIND_EQ_EQ    = 6'd13;
	localparam logic [5:0] KIND_LESS     = 6'd14;
	localparam logic [5:0] KIND_LESS_EQ  = 6'd15;
	localparam logic [5:0] KIND_GREATER  = 6'd16;
	localparam logic [5:0] KIND_GREAT_EQ = 6'd17;
	localparam logic [5:0] KIND_BANG     = 6'd18;
	localparam logic [5:0] KIND_BANG_EQ  = 6'd19;
	localparam logic [5:0] KIND_AMP      = 6'd20;
	localparam logic [5:0] KIND_AMP_EQ   = 6'd21;
	localparam logic [5:0] KIND_PIPE     = 6'd22;
	localparam logic [5:0] KIND_PIPE_EQ  = 6'd23;
	localparam logic [5:0] KIND_CARET    = 6'd24;
	localparam logic [5:0] KIND_CARET_EQ = 6'd25;
	localparam logic [5:0] KIND_TILDE    = 6'd26;
	localparam logic [5:0] KIND_MOD      = 6'd27;
	localparam logic [5:0] KIND_MOD_EQ   = 6'd28;
	localparam logic [5:0] KIND_COLON    = 6'd29;
	localparam logic [5:0] KIND_COMMA    = 6'd30;
	localparam logic [5:0] KIND_LPAREN   = 6'd31;
	localparam logic [5:0] KIND_RPAREN   = 6'd32;
	localparam logic [5:0] KIND_LBRACE   = 6'd33;
	localparam logic [5:0] KIND_RBRACE   = 6'd34;
	localparam logic [5:0] KIND_DOT      = 6'd35;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_US    = 8'h5F;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// Keywords packed first byte highest, right aligned.
	localparam logic [63:0] KW_WORD [KW_COUNT] = '{
		64'h646566,           64'h7072696e74,   64'h72657475726e, 64'h7768696c65,
		64'h627265616b,       64'h636f6e74696e7565, 64'h6966,     64'h656c6966,
		64'h656c7365,         64'h54727565,     64'h46616c7365,   64'h4e6f6e65,
		64'h616e64,           64'h6f72,         64'h6e6f74,       64'h70617373
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd5, 4'd6, 4'd5, 4'd5, 4'd8, 4'd2, 4'd4,
		4'd4, 4'd4, 4'd5, 4'd4, 4'd3, 4'd2, 4'd3, 4'd4
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
	} token_t;

	// One queue entry: every token caused by one input item.
	typedef struct packed {
		token_t tok0;
		token_t tok1;
		logic   two;
	} entry_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_op_char(input logic [7:0] c);
		logic r;
		case (c)
			"+", "-", "*", "/", "=", "<", ">", "!", "&", "|", "^", "~", "%", ":",
			",", "(", ")", "{", "}", "[", "]", CH_DOT, CH_LF, CH_CR: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic kw_match(input logic [63:0] win, input logic [15:0] len);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (win == KW_WORD[i] && len == {12'd0, KW_LEN[i]})
				hit = 1'b1;
		end
		return hit;
	endfunction

	// Kind of an operator run from its first byte and whether its second byte is '='.
	function automatic logic [5:0] op_kind(input logic [15:0] head, input logic two_plus);
		logic       eq;
		logic [5:0] k;
		eq = two_plus && head[7:0] == CH_EQ;
		unique case (head[15:8])
			"+": k = KIND_PLUS;
			"-": k = KIND_MINUS;
			"*": k = KIND_STAR;
			"/": k = KIND_SLASH;
			"=": k = eq ? KIND_EQ_EQ : KIND_ASSIGN;
			"<": k = eq ? KIND_LESS_EQ : KIND_LESS;
			">": k = eq ? KIND_GREAT_EQ : KIND_GREATER;
			"!": k = eq ? KIND_BANG_EQ : KIND_BANG;
			"&": k = eq ? KIND_AMP_EQ : KIND_AMP;
			"|": k = eq ? KIND_PIPE_EQ : KIND_PIPE;
			"^": k = eq ? KIND_CARET_EQ : KIND_CARET;
			"~": k = KIND_TILDE;
			"%": k = eq ? KIND_MOD_EQ : KIND_MOD;
			":": k = KIND_COLON;
			",": k = KIND_COMMA;
			"(": k = KIND_LPAREN;
			")": k = KIND_RPAREN;
			"{", "[": k = KIND_LBRACE;
			"}", "]": k = KIND_RBRACE;
			CH_DOT: k = KIND_DOT;
			CH_LF, CH_CR: k = KIND_NEWLINE;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

/* design/stst_front.sv */
// Front end of the script token scanner: scanner state and per-byte classification.
// Produces one queue entry per item that yields tokens. Depends on stst_pkg.
module stst_front #(
	parameter int POS_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            op,
	input  logic [7:0]      ch,
	output logic            push,
	output stst_pkg::entry_t entry
);
	import stst_pkg::*;

	localparam int PW = (POS_BITS > 16) ? POS_BITS : 16;

	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_IDENT  = 6'b000010,
		MODE_NUMBER = 6'b000100,
		MODE_DSTR   = 6'b001000,
		MODE_SSTR   = 6'b010000,
		MODE_OPRUN  = 6'b100000
	} mode_t;

	mode_t               mode_q, mode_d;
	logic [POS_BITS-1:0] pos_q, pos_d, start_q, start_d;
	logic [63:0]         win_q, win_d;
	logic                long_q, long_d, dot_q, dot_d;
	logic [15:0]         head_q, head_d, cnt_q, cnt_d, cnt_inc;
	logic [PW-1:0]       pos_w, start_w;
	logic [5:0]          fl_kind;
	token_t              a_tok, b_tok;
	logic                a_ok, b_ok, fresh;
	logic                c_alpha, c_digit, c_dot, c_us;

	assign pos_w   = PW'(pos_q);
	assign start_w = PW'(start_q);
	assign cnt_inc = (cnt_q == LEN_MAX) ? cnt_q : cnt_q + 16'd1;
	assign c_alpha = is_alpha(ch);
	assign c_digit = is_digit(ch);
	assign c_dot   = ch == CH_DOT;
	assign c_us    = ch == CH_US;

	// Kind of the pending token if it ends here.
	always_comb begin
		unique case (mode_q)
			MODE_IDENT:  fl_kind = (!long_q && kw_match(win_q, cnt_q)) ? KIND_KEYWORD
				: KIND_IDENT;
			MODE_NUMBER: fl_kind = dot_q ? KIND_FLOAT : KIND_INT;
			MODE_OPRUN:  fl_kind = op_kind(head_q, cnt_q >= 16'd2);
			MODE_DSTR, MODE_SSTR: fl_kind = KIND_ERROR;
			MODE_IDLE:   fl_kind = KIND_EOF;
			default:     fl_kind = KIND_EOF;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		start_d = start_q;
		win_d   = win_q;
		long_d  = long_q;
		dot_d   = dot_q;
		head_d  = head_q;
		cnt_d   = cnt_q;
		a_ok    = 1'b0;
		b_ok    = 1'b0;
		fresh   = 1'b0;
		a_tok   = '{kind: fl_kind, start: start_w[15:0], len: cnt_q};
		b_tok   = '{kind: KIND_NEWLINE, start: pos_w[15:0], len: 16'd1};
		if (op) begin
			// flush, then end of file, then back to reset state
			a_ok    = mode_q != MODE_IDLE;
			b_ok    = 1'b1;
			b_tok   = '{kind: KIND_EOF, start: pos_w[15:0], len: 16'd0};
			mode_d  = MODE_IDLE;
			pos_d   = '0;
			start_d = '0;
			win_d   = '0;
			long_d  = 1'b0;
			dot_d   = 1'b0;
			head_d  = '0;
			cnt_d   = '0;
		end else begin
			pos_d = pos_q + POS_BITS'(1);
			unique case (mode_q)
				MODE_IDENT: begin
					if (c_alpha || c_digit || c_us) begin
						if (cnt_q < 16'(KW_CHARS))
							win_d = {win_q[55:0], ch};
						else
							long_d = 1'b1;
						cnt_d = cnt_inc;
					end else begin
						fresh = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (c_digit || c_dot) begin
						dot_d = dot_q | c_dot;
						cnt_d = cnt_inc;
					end else begin
						fresh = 1'b1;
					end
				end
				MODE_DSTR, MODE_SSTR: begin
					if ((mode_q == MODE_DSTR && ch == CH_DQ) ||
					    (mode_q == MODE_SSTR && ch == CH_SQ)) begin
						a_ok   = 1'b1;
						a_tok  = '{kind: KIND_STRING, start: start_w[15:0], len: cnt_q};
						mode_d = MODE_IDLE;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				MODE_OPRUN: begin
					if (is_op_char(ch)) begin
						if (cnt_q == 16'd1)
							head_d[7:0] = ch;
						cnt_d = cnt_inc;
					end else begin
						fresh = 1'b1;
					end
				end
				MODE_IDLE: fresh = 1'b1;
				default:   fresh = 1'b1;
			endcase
			if (fresh) begin
				// drop the pending token into the queue and rescan this byte
				a_ok   = mode_q != MODE_IDLE;
				mode_d = MODE_IDLE;
				if (ch == CH_SPACE || ch == CH_TAB) begin
					mode_d = MODE_IDLE;
				end else if (ch == CH_LF || ch == CH_CR) begin
					b_ok = 1'b1;
				end else begin
					start_d = pos_q;
					win_d   = '0;
					long_d  = 1'b0;
					dot_d   = 1'b0;
					head_d  = '0;
					cnt_d   = 16'd1;
					if (c_alpha || c_us) begin
						mode_d = MODE_IDENT;
						win_d  = {56'd0, ch};
					end else if (c_digit || c_dot) begin
						mode_d = MODE_NUMBER;
						dot_d  = c_dot;
					end else if (ch == CH_DQ || ch == CH_SQ) begin
						mode_d  = (ch == CH_DQ) ? MODE_DSTR : MODE_SSTR;
						start_d = pos_q + POS_BITS'(1);
						cnt_d   = 16'd0;
					end else begin
						mode_d = MODE_OPRUN;
						head_d = {ch, 8'h00};
					end
				end
			end
		end
	end

	assign push       = accept && (a_ok || b_ok);
	assign entry.tok0 = a_ok ? a_tok : b_tok;
	assign entry.tok1 = b_tok;
	assign entry.two  = a_ok && b_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			win_q   <= '0;
			long_q  <= 1'b0;
			dot_q   <= 1'b0;
			head_q  <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			win_q   <= win_d;
			long_q  <= long_d;
			dot_q   <= dot_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

/* design/stst_fifo.sv */
// Short queue of token entries between the scanner front and back ends.
// Depends on stst_pkg for the entry type.
module stst_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stst_pkg::entry_t push_data,
	input  logic             pop,
	output stst_pkg::entry_t head,
	output logic             empty,
	output logic             full
);
	import stst_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        slot_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty   = count_q == '0;
	assign full    = count_q == CW'(DEPTH);
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

/* design/stst_back.sv */
// Back end of the script token scanner: splits queue entries into single tokens
// and holds them in the output register. Depends on stst_pkg.
module stst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  stst_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [5:0]       token_kind,
	output logic [15:0]      start_pos,
	output logic [15:0]      lexeme_len,
	output logic             last_of_run
);
	import stst_pkg::*;

	logic   valid_q, phase_q, last_q;
	token_t tok_q, sel;
	logic   load, take, sel_last;

	assign load     = !valid_q || !out_stall;
	assign take     = load && !empty;
	assign sel      = phase_q ? head.tok1 : head.tok0;
	assign sel_last = phase_q || !head.two;
	assign pop      = take && sel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= !empty;
			if (take)
				phase_q <= !sel_last;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_q  <= sel;
			last_q <= sel_last;
		end
	end

	assign out_valid   = valid_q;
	assign token_kind  = tok_q.kind;
	assign start_pos   = tok_q.start;
	assign lexeme_len  = tok_q.len;
	assign last_of_run = last_q;

endmodule

/* design/script_token_scanner_core.sv */
// Script token scanner core: one source byte or end-of-input mark per item, tokens out.
// A token passes from its accepted item through a queue entry into the output register.
// Throughput: one item per cycle while the queue has room; the output port moves one token
// per cycle unless stalled; two-token items go out in turn (queue absorbs the burst).
// Reset (arst_n low, asynchronous): scanner idle at position 0, queue and output empty.
// Depends on stst_pkg, stst_front, stst_fifo, stst_back and the assertion header.
`include "script_token_scanner_core_assert.svh"

module script_token_scanner_core #(
	parameter int POS_BITS   = 16,
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [15:0] start_pos,
	output logic [15:0] lexeme_len,
	output logic        last_of_run
);
	import stst_pkg::*;

	logic   accept;
	logic   q_push, q_pop, q_empty, q_full;
	entry_t q_in, q_head;

	// Hold the input whenever the queue has no room; the front end then
	// keeps its state and the item waits on the port.
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// Front: scanner state, classification of each byte, up to two tokens
	// per item packed into a single queue entry.
	stst_front #(
		.POS_BITS(POS_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (op),
		.ch     (ch),
		.push   (q_push),
		.entry  (q_in)
	);

	// Queue: decouples the scanner from a stalled consumer.
	stst_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back: advance through the tokens of each entry, one per cycle unless stalled, and
	// mark the final one of each item.
	stst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.token_kind  (token_kind),
		.start_pos   (start_pos),
		.lexeme_len  (lexeme_len),
		.last_of_run (last_of_run)
	);

	// The front end never writes into a full queue.
	`STST_ASSERT_IMP(a_no_push_when_full, q_push, !q_full)
	// The second token of an item follows straight after the first is taken.
	`STST_ASSERT_NXT(a_run_continues, out_valid && !out_stall && !last_of_run, out_valid)
	// End of input always leaves at least its end-of-file token in flight.
	`STST_ASSERT_NXT(a_eof_in_flight, accept && op, out_valid || !q_empty)

endmodule
